// ===== sv/llh_pkg.sv =====
// ----------------------------------------------------------------------------
// llh_pkg
// Shared widths, codes, state and command types for the log2 latency
// histogram, plus the leading-one search used for bucket selection.
// ----------------------------------------------------------------------------
package llh_pkg;

    // Field widths of the item channels
    localparam int REQ_W   = 2;
    localparam int PROC_W  = 22;
    localparam int SLOT_W  = 10;
    localparam int CALL_W  = 10;
    localparam int TIME_W  = 64;
    localparam int RIDX_W  = 5;
    localparam int BKT_W   = 5;
    localparam int COUNT_W = 64;

    // Leading-one index of a TIME_W word
    localparam int MSB_W = 6;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ENTRY = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EXIT  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // Register indexes
    localparam logic REG_FILTER_PROCESS = 1'b0;
    localparam logic REG_FILTER_CALL    = 1'b1;

    localparam logic [CALL_W-1:0] FILTER_CALL_RESET = 10'd63;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_BKT,
        ST_FIN
    } llh_state_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_we;
        logic capture;
        logic diff_en;
        logic bkt_en;
        logic commit;
    } llh_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } llh_status_t;

    // floor(log2(value)); 0 and 1 both give 0
    function automatic logic [MSB_W-1:0] msb_index(input logic [TIME_W-1:0] value);
        logic [TIME_W-1:0] v;
        logic [MSB_W-1:0]  idx;
        v   = value;
        idx = '0;
        if (v[63:32] != '0)
        begin
            idx[5] = 1'b1;
            v      = v >> 32;
        end
        if (v[31:16] != '0)
        begin
            idx[4] = 1'b1;
            v      = v >> 16;
        end
        if (v[15:8] != '0)
        begin
            idx[3] = 1'b1;
            v      = v >> 8;
        end
        if (v[7:4] != '0)
        begin
            idx[2] = 1'b1;
            v      = v >> 4;
        end
        if (v[3:2] != '0)
        begin
            idx[1] = 1'b1;
            v      = v >> 2;
        end
        if (v[1])
        begin
            idx[0] = 1'b1;
        end
        return idx;
    endfunction

endpackage

// ===== sv/llh_req_if.sv =====
// ----------------------------------------------------------------------------
// llh_req_if
// Request channel: valid/ready handshake with entry, exit and read payload.
// ----------------------------------------------------------------------------
interface llh_req_if
    import llh_pkg::*;
();

    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [PROC_W-1:0] process_id;
    logic [SLOT_W-1:0] thread_slot;
    logic [CALL_W-1:0] call_number;
    logic [TIME_W-1:0] time_ns;
    logic [RIDX_W-1:0] read_index;

    modport source (
        output valid, req_type, process_id, thread_slot, call_number, time_ns, read_index,
        input  ready
    );

    modport sink (
        input  valid, req_type, process_id, thread_slot, call_number, time_ns, read_index,
        output ready
    );

endinterface

// ===== sv/llh_rsp_if.sv =====
// ----------------------------------------------------------------------------
// llh_rsp_if
// Result channel: valid/ready handshake with one result item per request.
// ----------------------------------------------------------------------------
interface llh_rsp_if
    import llh_pkg::*;
();

    logic               valid;
    logic               ready;
    logic               accepted;
    logic [BKT_W-1:0]   bucket;
    logic [COUNT_W-1:0] bucket_count;
    logic [TIME_W-1:0]  latency_ns;

    modport source (
        output valid, accepted, bucket, bucket_count, latency_ns,
        input  ready
    );

    modport sink (
        input  valid, accepted, bucket, bucket_count, latency_ns,
        output ready
    );

endinterface

// ===== sv/llh_ctrl.sv =====
// ----------------------------------------------------------------------------
// llh_ctrl
// Sequencer: clear pass after reset, then one item at a time through
// capture, difference, bucket lookup and commit.
// ----------------------------------------------------------------------------
module llh_ctrl
    import llh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  llh_status_t status,
    output llh_cmd_t    cmd
);

    llh_state_t state_reg;
    llh_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                cmd.diff_en = 1'b1;
                state_next  = ST_BKT;
            end
            ST_BKT:
            begin
                cmd.bkt_en = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/llh_dp.sv =====
// ----------------------------------------------------------------------------
// llh_dp
// Datapath: timestamp and valid-mark memories per thread, bucket counter
// memory, duration and bucket arithmetic, and the result register.
// ----------------------------------------------------------------------------
module llh_dp
    import llh_pkg::*;
#(
    parameter int THREAD_SLOTS = 1024,
    parameter int BUCKETS      = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  llh_cmd_t          cmd,
    output llh_status_t       status,
    input  logic [PROC_W-1:0] filter_process,
    input  logic [CALL_W-1:0] filter_call,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [PROC_W-1:0] process_id,
    input  logic [SLOT_W-1:0] thread_slot,
    input  logic [CALL_W-1:0] call_number,
    input  logic [TIME_W-1:0] time_ns,
    input  logic [RIDX_W-1:0] read_index,
    llh_rsp_if.source         rsp
);

    localparam int SLOT_AW = $clog2(THREAD_SLOTS);
    localparam int BKT_AW  = $clog2(BUCKETS);
    localparam logic [SLOT_AW-1:0] SLOT_LAST = SLOT_AW'(THREAD_SLOTS - 1);
    localparam logic [BKT_AW-1:0]  BKT_LAST  = BKT_AW'(BUCKETS - 1);

    // Memories
    logic [TIME_W-1:0]  stamp_mem [THREAD_SLOTS];
    logic               valid_mem [THREAD_SLOTS];
    logic [COUNT_W-1:0] count_mem [BUCKETS];
    logic [BUCKETS-1:0] count_valid_reg;

    // Captured item
    logic [REQ_W-1:0]  req_reg;
    logic [PROC_W-1:0] pid_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [CALL_W-1:0] call_reg;
    logic [TIME_W-1:0] time_reg;
    logic [RIDX_W-1:0] ridx_reg;
    logic [TIME_W-1:0] stamp_rd_reg;
    logic              valid_rd_reg;

    // Decision and arithmetic
    logic              entry_ok_reg;
    logic              exit_ok_reg;
    logic              read_ok_reg;
    logic [TIME_W-1:0] diff_reg;
    logic [BKT_AW-1:0] bkt_reg;
    logic [COUNT_W-1:0] cnt_rd_reg;
    logic              cnt_hit_reg;

    // Clear pass
    logic [SLOT_AW-1:0] clr_idx_reg;

    // Result register
    logic               out_valid_reg;
    logic               out_accepted_reg;
    logic [BKT_W-1:0]   out_bucket_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [TIME_W-1:0]  out_latency_reg;

    logic [31:0]        in_slot_wide;
    logic [SLOT_AW-1:0] in_idx;
    logic [31:0]        slot_wide;
    logic [SLOT_AW-1:0] slot_idx;
    logic               slot_ok;
    logic               proc_pass;
    logic               entry_ok_next;
    logic               exit_ok_next;
    logic               read_ok_next;
    logic [TIME_W-1:0]  diff_next;
    logic [MSB_W-1:0]   msb;
    logic [31:0]        msb_wide;
    logic [31:0]        ridx_wide;
    logic [BKT_AW-1:0]  dur_bkt;
    logic [BKT_AW-1:0]  bkt_next;
    logic [COUNT_W-1:0] cnt_cur;
    logic [COUNT_W-1:0] cnt_inc;
    logic [31:0]        bkt_wide;

    // Index forms of the slot fields
    assign in_slot_wide = 32'(thread_slot);
    assign in_idx       = in_slot_wide[SLOT_AW-1:0];
    assign slot_wide    = 32'(slot_reg);
    assign slot_idx     = slot_wide[SLOT_AW-1:0];

    // Filters on the captured item
    assign slot_ok       = slot_wide < 32'(THREAD_SLOTS);
    assign proc_pass     = (filter_process == '0) || (pid_reg == filter_process);
    assign entry_ok_next = (req_reg == REQ_ENTRY) && slot_ok && proc_pass
                           && (call_reg == filter_call);
    assign exit_ok_next  = (req_reg == REQ_EXIT) && slot_ok && proc_pass && valid_rd_reg;
    assign read_ok_next  = (req_reg == REQ_READ) && (32'(ridx_reg) < 32'(BUCKETS));
    assign diff_next     = time_reg - stamp_rd_reg;

    // Bucket of the duration, clamped to the last bucket
    assign msb       = msb_index(diff_reg);
    assign msb_wide  = 32'(msb);
    assign dur_bkt   = (msb_wide > 32'(BUCKETS - 1)) ? BKT_LAST : msb_wide[BKT_AW-1:0];
    assign ridx_wide = 32'(ridx_reg);
    assign bkt_next  = exit_ok_reg ? dur_bkt : ridx_wide[BKT_AW-1:0];

    // Counter value, never-written buckets read as zero
    assign cnt_cur  = cnt_hit_reg ? cnt_rd_reg : '0;
    assign cnt_inc  = cnt_cur + COUNT_W'(1);
    assign bkt_wide = 32'(bkt_reg);

    assign status.clr_last = (clr_idx_reg == SLOT_LAST);
    assign status.out_free = !out_valid_reg || rsp.ready;

    // Capture item and read thread slot
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg      <= req_type;
            pid_reg      <= process_id;
            slot_reg     <= thread_slot;
            call_reg     <= call_number;
            time_reg     <= time_ns;
            ridx_reg     <= read_index;
            stamp_rd_reg <= stamp_mem[in_idx];
            valid_rd_reg <= valid_mem[in_idx];
        end
    end

    // Write timestamp on a recorded entry
    always_ff @(posedge clk)
    begin
        if (cmd.commit && entry_ok_reg)
        begin
            stamp_mem[slot_idx] <= time_reg;
        end
    end

    // Valid marks: clear pass, then set on entry and drop on exit
    always_ff @(posedge clk)
    begin
        if (cmd.clr_we)
        begin
            valid_mem[clr_idx_reg] <= 1'b0;
        end
        else if (cmd.commit && (entry_ok_reg || exit_ok_reg))
        begin
            valid_mem[slot_idx] <= entry_ok_reg;
        end
    end

    // Clear pass address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (cmd.clr_we)
        begin
            clr_idx_reg <= clr_idx_reg + SLOT_AW'(1);
        end
    end

    // Decide and take the duration
    always_ff @(posedge clk)
    begin
        if (cmd.diff_en)
        begin
            entry_ok_reg <= entry_ok_next;
            exit_ok_reg  <= exit_ok_next;
            read_ok_reg  <= read_ok_next;
            diff_reg     <= diff_next;
        end
    end

    // Select bucket and read its counter
    always_ff @(posedge clk)
    begin
        if (cmd.bkt_en)
        begin
            bkt_reg     <= bkt_next;
            cnt_rd_reg  <= count_mem[bkt_next];
            cnt_hit_reg <= count_valid_reg[bkt_next];
        end
    end

    // Write back the incremented counter
    always_ff @(posedge clk)
    begin
        if (cmd.commit && exit_ok_reg)
        begin
            count_mem[bkt_reg] <= cnt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_valid_reg <= '0;
        end
        else if (cmd.commit && exit_ok_reg)
        begin
            count_valid_reg[bkt_reg] <= 1'b1;
        end
    end

    // Result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload; fields not used by the outcome are zero
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_accepted_reg <= entry_ok_reg || exit_ok_reg || read_ok_reg;
            out_bucket_reg   <= (exit_ok_reg || read_ok_reg) ? bkt_wide[BKT_W-1:0] : '0;
            out_count_reg    <= exit_ok_reg ? cnt_inc : (read_ok_reg ? cnt_cur : '0);
            out_latency_reg  <= exit_ok_reg ? diff_reg : '0;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.accepted     = out_accepted_reg;
    assign rsp.bucket       = out_bucket_reg;
    assign rsp.bucket_count = out_count_reg;
    assign rsp.latency_ns   = out_latency_reg;

endmodule

// ===== sv/latency_log2_histogram.sv =====
// Flow: one item at a time, through capture, difference, bucket lookup and
// commit, with a read-modify-write chain through the timestamp memory and
// then the bucket counter memory; commit waits while the result is unread.
// Reset: asynchronous, active low. After reset a clearing pass over all
// THREAD_SLOTS slots drops every valid mark; no item is accepted until it
// ends, while register writes are taken throughout.
// ----------------------------------------------------------------------------
// latency_log2_histogram
// Pairs call entry and exit events per thread and counts call durations
// in power-of-two buckets; serves bucket reads and an APB register port.
// ----------------------------------------------------------------------------
module latency_log2_histogram
    import llh_pkg::*;
#(
    parameter int THREAD_SLOTS = 1024,
    parameter int BUCKETS      = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    llh_req_if.sink           req,
    llh_rsp_if.source         rsp
);

    logic [PROC_W-1:0] filter_process_reg;
    logic [CALL_W-1:0] filter_call_reg;
    logic              cfg_write;
    logic              in_ready;
    llh_cmd_t          cmd;
    llh_status_t       status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Filter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_process_reg <= '0;
            filter_call_reg    <= FILTER_CALL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[APB_AW-1])
                REG_FILTER_PROCESS: filter_process_reg <= pwdata[PROC_W-1:0];
                REG_FILTER_CALL:    filter_call_reg    <= pwdata[CALL_W-1:0];
                default:            filter_call_reg    <= filter_call_reg;
            endcase
        end
    end

    // Register read back
    always_comb
    begin
        unique case (paddr[APB_AW-1])
            REG_FILTER_PROCESS: prdata = APB_DW'(filter_process_reg);
            REG_FILTER_CALL:    prdata = APB_DW'(filter_call_reg);
            default:            prdata = '0;
        endcase
    end

    assign req.ready = in_ready;

    llh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    llh_dp #(
        .THREAD_SLOTS (THREAD_SLOTS),
        .BUCKETS      (BUCKETS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .filter_process (filter_process_reg),
        .filter_call    (filter_call_reg),
        .req_type       (req.req_type),
        .process_id     (req.process_id),
        .thread_slot    (req.thread_slot),
        .call_number    (req.call_number),
        .time_ns        (req.time_ns),
        .read_index     (req.read_index),
        .rsp            (rsp)
    );

    // One item in flight: no new request right after one is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while an item is in flight");

    // A captured item moves on to the difference step
    a_capture_flow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.diff_en)
        else $error("captured item did not advance");

    // Commit never overwrites a result still waiting
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!rsp.valid || rsp.ready))
        else $error("result overwritten before it was taken");

    // A rejected request carries zero fields
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.accepted) |->
            (rsp.bucket == '0 && rsp.bucket_count == '0 && rsp.latency_ns == '0))
        else $error("rejected item has nonzero fields");

endmodule

// ===== tb/llh_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// llh_checker
// Watches the register port and both item channels of the latency
// histogram, keeps its own copy of the timestamp table, the bucket
// counters and the filters, and compares every result item with the
// oldest expected one.
// ----------------------------------------------------------------------------
module llh_checker
    import llh_pkg::*;
#(
    parameter int THREAD_SLOTS = 1024,
    parameter int BUCKETS      = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              pready,
    llh_req_if                req,
    llh_rsp_if                rsp,
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        logic               accepted;
        logic [BKT_W-1:0]   bucket;
        logic [COUNT_W-1:0] bucket_count;
        logic [TIME_W-1:0]  latency_ns;
    } hist_result_t;

    logic [TIME_W-1:0]  entry_time [THREAD_SLOTS];
    logic               entry_open [THREAD_SLOTS];
    logic [COUNT_W-1:0] hist_count [BUCKETS];
    logic [PROC_W-1:0]  track_proc;
    logic [CALL_W-1:0]  track_call;
    hist_result_t       expected_q [$];

    // floor(log2) of a duration, 0 and 1 in the lowest bucket, clamped at the top
    function automatic int unsigned duration_to_bucket(input logic [TIME_W-1:0] span);
        int unsigned b;
        b = 0;
        while (span > 1)
        begin
            span = span >> 1;
            b++;
        end
        if (b > BUCKETS - 1)
            b = BUCKETS - 1;
        return b;
    endfunction

    // Apply one request to the tracked state and return the result it causes
    function automatic hist_result_t histogram_update(
        input logic [REQ_W-1:0]  kind,
        input logic [PROC_W-1:0] pid,
        input logic [SLOT_W-1:0] slot,
        input logic [CALL_W-1:0] call,
        input logic [TIME_W-1:0] stamp,
        input logic [RIDX_W-1:0] ridx
    );
        hist_result_t res;
        logic         pid_ok;
        logic [TIME_W-1:0] span;
        int unsigned  b;
        res    = '0;
        pid_ok = (track_proc == '0) || (pid == track_proc);
        if (kind == REQ_ENTRY)
        begin
            if (slot < THREAD_SLOTS && pid_ok && call == track_call)
            begin
                entry_time[slot] = stamp;
                entry_open[slot] = 1'b1;
                res.accepted     = 1'b1;
            end
        end
        else if (kind == REQ_EXIT)
        begin
            if (slot < THREAD_SLOTS && pid_ok && entry_open[slot])
            begin
                span             = stamp - entry_time[slot];
                b                = duration_to_bucket(span);
                entry_open[slot] = 1'b0;
                hist_count[b]    = hist_count[b] + COUNT_W'(1);
                res.accepted     = 1'b1;
                res.bucket       = b[BKT_W-1:0];
                res.bucket_count = hist_count[b];
                res.latency_ns   = span;
            end
        end
        else if (kind == REQ_READ)
        begin
            if (ridx < BUCKETS)
            begin
                res.accepted     = 1'b1;
                res.bucket       = ridx;
                res.bucket_count = hist_count[ridx];
            end
        end
        return res;
    endfunction

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: result %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what,
                 got, want);
        fail_count++;
    endtask

    // Track the register port, predict on each request item, check each result item
    always @(posedge clk or negedge rst_n)
    begin
        hist_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < THREAD_SLOTS; i++)
                entry_open[i] = 1'b0;
            for (int i = 0; i < BUCKETS; i++)
                hist_count[i] = '0;
            track_proc = '0;
            track_call = FILTER_CALL_RESET;
            expected_q.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
            begin
                if (paddr[APB_AW-1:2] == REG_FILTER_PROCESS)
                    track_proc = pwdata[PROC_W-1:0];
                else if (paddr[APB_AW-1:2] == REG_FILTER_CALL)
                    track_call = pwdata[CALL_W-1:0];
            end
            if (req.valid && req.ready)
                expected_q.push_back(histogram_update(req.req_type, req.process_id,
                                                      req.thread_slot, req.call_number,
                                                      req.time_ns, req.read_index));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected item", 64'(rsp.bucket), '0);
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.accepted !== want.accepted)
                        report_mismatch("accepted", 64'(rsp.accepted), 64'(want.accepted));
                    if (rsp.bucket !== want.bucket)
                        report_mismatch("bucket", 64'(rsp.bucket), 64'(want.bucket));
                    if (rsp.bucket_count !== want.bucket_count)
                        report_mismatch("bucket_count", rsp.bucket_count, want.bucket_count);
                    if (rsp.latency_ns !== want.latency_ns)
                        report_mismatch("latency_ns", rsp.latency_ns, want.latency_ns);
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the latency histogram with directed entry, exit and read items,
// then random paired call sequences under several filter settings, with
// random idling on both channels, a long result hold-off and drains.
// ----------------------------------------------------------------------------
module tb;
    import llh_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int               NUM_SLOTS  = 1024;
    localparam int               CYCLE_CAP  = 400000;
    localparam int               HOLD_LEN   = 300;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                fails;
    int                pending;
    int                cycles;

    // Shared between stimulus and the result receiver; hold_left is the receiver's own
    bit                no_gaps;
    bit                hold_request;
    int                hold_left;

    // Stimulus bookkeeping
    logic [PROC_W-1:0] cur_proc;
    logic [CALL_W-1:0] cur_call;
    logic [TIME_W-1:0] clock_ns;
    logic [TIME_W-1:0] last_entry [NUM_SLOTS];

    llh_req_if req_ch ();
    llh_rsp_if rsp_ch ();

    latency_log2_histogram i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    llh_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fails),
        .pending    (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result receiver: random stalls, a long hold-off on request
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_LEN;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 38);
        end
    end

    // Offer one request item and hold it until accepted
    task automatic send_event(input logic [REQ_W-1:0] kind, input logic [PROC_W-1:0] pid,
                              input logic [SLOT_W-1:0] slot, input logic [CALL_W-1:0] call,
                              input logic [TIME_W-1:0] stamp,
                              input logic [RIDX_W-1:0] ridx);
        while (!no_gaps && $urandom_range(0, 99) < 38)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.process_id  <= pid;
        req_ch.thread_slot <= slot;
        req_ch.call_number <= call;
        req_ch.time_ns     <= stamp;
        req_ch.read_index  <= ridx;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every expected result item has arrived
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Register write with setup and access phases; junk in the upper bits checks masking
    task automatic write_reg(input logic idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drain, let the pipeline settle, then load both filters
    task automatic set_filters(input logic [PROC_W-1:0] proc, input logic [CALL_W-1:0] call);
        wait_for_results();
        repeat (4) @(posedge clk);
        write_reg(REG_FILTER_PROCESS, {10'($urandom_range(0, 1023)), proc});
        write_reg(REG_FILTER_CALL, {22'($urandom_range(0, 4194303)), call});
        cur_proc = proc;
        cur_call = call;
    endtask

    // Boundary durations, filter misses, overwrite, double exit, reads
    task automatic directed_events();
        logic [TIME_W-1:0] ones;
        ones = '1;
        send_event(REQ_READ, '0, '0, '0, '0, 5'd0);
        send_event(REQ_ENTRY, '0, 10'd0, 10'd5, 64'd100, '0);
        send_event(REQ_EXIT, '0, 10'd0, 10'd0, 64'd100, '0);
        send_event(REQ_ENTRY, '1, 10'd1023, 10'd5, 64'd10, '1);
        send_event(REQ_EXIT, '1, 10'd1023, '1, 64'd11, '1);
        send_event(REQ_ENTRY, '0, 10'd2, 10'd5, 64'd0, '0);
        send_event(REQ_EXIT, '0, 10'd2, 10'd5, 64'd3, '0);
        // wrong call number, then an exit that finds nothing
        send_event(REQ_ENTRY, '0, 10'd6, 10'd1023, 64'd7, '0);
        send_event(REQ_EXIT, '0, 10'd6, 10'd5, 64'd9, '0);
        // wrapping differences
        send_event(REQ_ENTRY, '0, 10'd3, 10'd5, ones, '0);
        send_event(REQ_EXIT, '0, 10'd3, 10'd5, 64'd0, '0);
        send_event(REQ_ENTRY, '0, 10'd4, 10'd5, 64'd1, '0);
        send_event(REQ_EXIT, '0, 10'd4, 10'd5, 64'd0, '0);
        // either side of the top bucket
        send_event(REQ_ENTRY, '0, 10'd7, 10'd5, 64'd0, '0);
        send_event(REQ_EXIT, '0, 10'd7, 10'd5, 64'h7FFF_FFFF, '0);
        send_event(REQ_ENTRY, '0, 10'd8, 10'd5, 64'd5, '0);
        send_event(REQ_EXIT, '0, 10'd8, 10'd5, 64'h8000_0005, '0);
        // overwrite an open entry, then exit twice
        send_event(REQ_ENTRY, '0, 10'd5, 10'd5, 64'd0, '0);
        send_event(REQ_ENTRY, '0, 10'd5, 10'd5, 64'd100, '0);
        send_event(REQ_EXIT, '0, 10'd5, 10'd5, 64'd108, '0);
        send_event(REQ_EXIT, '0, 10'd5, 10'd5, 64'd200, '0);
        send_event(REQ_UNUSED, '1, '1, '1, ones, '1);
        send_event(REQ_READ, '1, '1, '1, ones, 5'd31);
        send_event(REQ_READ, '0, '0, '0, '0, 5'd3);
    endtask

    // Mostly paired entry and exit items on a few slots, plus noise
    task automatic random_events(input int count, input int drain_at);
        logic [REQ_W-1:0]  kind;
        logic [PROC_W-1:0] pid;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] slot_base;
        logic [CALL_W-1:0] call;
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] span;
        int                pick;
        slot_base = 10'($urandom_range(0, NUM_SLOTS - 8));
        for (int n = 0; n < count; n++)
        begin
            if (n == drain_at)
                wait_for_results();
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                slot = 10'($urandom_range(0, NUM_SLOTS - 1));
            else
                slot = slot_base + 10'($urandom_range(0, 7));
            if (cur_proc == '0 || $urandom_range(0, 4) == 0)
                pid = 22'($urandom_range(0, 4194303));
            else
                pid = cur_proc;
            call  = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023)) : cur_call;
            stamp = {$urandom, $urandom};
            if (pick < 42)
            begin
                kind = REQ_ENTRY;
                if ($urandom_range(0, 2) != 0)
                begin
                    clock_ns += 64'($urandom_range(1, 1000));
                    stamp = clock_ns;
                end
                last_entry[slot] = stamp;
            end
            else if (pick < 84)
            begin
                kind = REQ_EXIT;
                span = {$urandom, $urandom} >> $urandom_range(0, 63);
                if ($urandom_range(0, 9) != 0)
                    stamp = last_entry[slot] + span;
            end
            else if (pick < 96)
                kind = REQ_READ;
            else
                kind = REQ_UNUSED;
            send_event(kind, pid, slot, call, stamp, 5'($urandom_range(0, 31)));
        end
    endtask

    // Reset, directed part, random phases, verdict
    initial
    begin
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_ENTRY;
        req_ch.process_id  <= '0;
        req_ch.thread_slot <= '0;
        req_ch.call_number <= '0;
        req_ch.time_ns     <= '0;
        req_ch.read_index  <= '0;
        clock_ns           = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
            last_entry[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_filters('0, 10'd5);
        directed_events();

        // lowest filter values
        set_filters('0, '0);
        random_events(165, -1);

        // highest filter values, no idling on either side
        set_filters('1, '1);
        no_gaps = 1'b1;
        random_events(165, -1);
        no_gaps = 1'b0;

        // back-pressure: hold results while requests keep coming
        set_filters(22'($urandom_range(1, 4194302)), 10'd63);
        hold_request = 1'b1;
        random_events(165, -1);

        // sender pauses mid-phase until every result is in
        set_filters('0, 10'($urandom_range(0, 1023)));
        random_events(165, 80);

        wait_for_results();
        repeat (10) @(posedge clk);
        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
sv/llh_pkg.sv
sv/llh_req_if.sv
sv/llh_rsp_if.sv
sv/llh_ctrl.sv
sv/llh_dp.sv
sv/latency_log2_histogram.sv
tb/llh_checker.sv
tb/tb.sv
